@@ src/bmhq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary min-heap queue package
// Shared constants, operation codes and result status codes.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int unsigned HEAP_DEPTH_DEF = 255;
  localparam int unsigned KEY_BITS_DEF   = 32;

  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  localparam logic [7:0] CAP_RESET = 8'd255;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

@@ src/bmhq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap slot memory
// Synchronous memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned AW      = 8,
  parameter int unsigned DW      = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_a_o,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem [0:ENTRIES-1];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

@@ src/binary_min_heap_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary min-heap priority queue
// Holds up to HEAP_DEPTH unsigned keys in a one-based heap kept in a memory.
//
// Requests arrive on the in_valid_i / in_ready_o channel: kind_i selects an
// insert of key_i or an extract of the smallest key. Every request yields one
// result on out_valid_o / out_ready_i carrying out_key_o, status_o and count_o.
// cfg_we_i loads the capacity limit register from cfg_wdata_i.
//
// One request is in flight at a time. An insert walks up one heap level per
// cycle and an extract walks down one level per cycle; each insert level costs
// one read of the slot memory and each extract level two reads, one per port.
//
// Reset empties the queue and sets the capacity limit to 255; the slot memory
// is not cleared since only occupied slots are read. A finished result waits
// in the output register while the receiver stalls, and the next request is
// still accepted and processed up to the point where its result is stored.
// ----------------------------------------------------------------------------
module binary_min_heap_queue
  import bmhq_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = HEAP_DEPTH_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [31:0] key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_key_o,
  output logic [1:0]  status_o,
  output logic [7:0]  count_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  localparam int unsigned ENTRIES = HEAP_DEPTH + 1;
  localparam int unsigned AW      = $clog2(ENTRIES);
  localparam int unsigned KW      = KEY_BITS;
  localparam logic [AW-1:0] DEPTH_A = AW'(HEAP_DEPTH);
  localparam logic [AW-1:0] ROOT    = AW'(1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_START   = 7'b0000010,
    S_UP_CMP  = 7'b0000100,
    S_UP_FIN  = 7'b0001000,
    S_DN_LOAD = 7'b0010000,
    S_DN_CMP  = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  logic          kind_q, kind_d;
  logic [KW-1:0] val_q, val_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [KW-1:0] res_key_q, res_key_d;
  status_e       res_st_q, res_st_d;
  logic          lok_q, lok_d;
  logic          rok_q, rok_d;
  logic [7:0]    cap_q;

  logic          out_valid_q;
  logic [31:0]   out_key_q;
  status_e       out_st_q;
  logic [7:0]    out_cnt_q;
  logic          out_load;

  logic          we;
  logic [AW-1:0] waddr;
  logic [KW-1:0] wdata;
  logic [AW-1:0] ra_a;
  logic [AW-1:0] ra_b;
  logic [KW-1:0] rd_a;
  logic [KW-1:0] rd_b;

  logic [AW-1:0] ch_pos;
  logic [AW-1:0] n_cur;
  logic          issue_dn;
  logic [AW:0]   lft;
  logic [AW:0]   rgt;
  logic [AW:0]   n_ext;
  logic          l_ok;
  logic          r_ok;

  logic [KW+31:0] key_ext;
  logic [KW+31:0] okey_ext;
  logic [AW+7:0]  cnt_ext;
  logic [AW+7:0]  cap_ext;
  logic           full;
  logic [AW-1:0]  cnt_inc;
  logic [AW-1:0]  par;
  logic           cl;
  logic           cr;
  logic [AW:0]    child;

  assign key_ext  = {{KW{1'b0}}, key_i};
  assign okey_ext = {32'd0, res_key_q};
  assign cnt_ext  = {8'd0, cnt_q};
  assign cap_ext  = {{AW{1'b0}}, cap_q};
  assign full     = (cnt_ext >= cap_ext) || (cnt_q >= DEPTH_A);
  assign cnt_inc  = cnt_q + ROOT;
  assign par      = pos_q >> 1;

  assign lft   = {ch_pos, 1'b0};
  assign rgt   = {ch_pos, 1'b1};
  assign n_ext = {1'b0, n_cur};
  assign l_ok  = issue_dn && (lft <= n_ext);
  assign r_ok  = issue_dn && (rgt <= n_ext);

  assign cl    = lok_q && (rd_a < val_q);
  assign cr    = rok_q && (rd_b < (cl ? rd_a : val_q));
  assign child = cr ? {pos_q, 1'b1} : {pos_q, 1'b0};

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    val_d     = val_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    res_key_d = res_key_q;
    res_st_d  = res_st_q;
    lok_d     = lok_q;
    rok_d     = rok_q;
    we        = 1'b0;
    waddr     = pos_q;
    wdata     = val_q;
    ra_a      = '0;
    ra_b      = '0;
    ch_pos    = ROOT;
    n_cur     = cnt_q;
    issue_dn  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_i;
          val_d   = key_ext[KW-1:0];
          state_d = S_START;
        end
      end
      S_START: begin
        res_key_d = '0;
        res_st_d  = ST_OK;
        if (kind_q == KIND_INSERT) begin
          if (full) begin
            res_st_d = ST_FULL;
            state_d  = S_DONE;
          end else begin
            cnt_d = cnt_inc;
            pos_d = cnt_inc;
            if (cnt_q == '0) begin
              we      = 1'b1;
              waddr   = ROOT;
              state_d = S_DONE;
            end else begin
              ra_a    = cnt_inc >> 1;
              state_d = S_UP_CMP;
            end
          end
        end else begin
          if (cnt_q == '0) begin
            res_st_d = ST_EMPTY;
            state_d  = S_DONE;
          end else begin
            ra_a    = ROOT;
            ra_b    = cnt_q;
            state_d = S_DN_LOAD;
          end
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (val_q < rd_a) begin
          wdata = rd_a;
          pos_d = par;
          if (par == ROOT) begin
            state_d = S_UP_FIN;
          end else begin
            ra_a = par >> 1;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_UP_FIN: begin
        we      = 1'b1;
        state_d = S_DONE;
      end
      S_DN_LOAD: begin
        res_key_d = rd_a;
        val_d     = rd_b;
        cnt_d     = cnt_q - ROOT;
        pos_d     = ROOT;
        ch_pos    = ROOT;
        n_cur     = cnt_q - ROOT;
        issue_dn  = 1'b1;
        ra_a      = l_ok ? lft[AW-1:0] : '0;
        ra_b      = r_ok ? rgt[AW-1:0] : '0;
        lok_d     = l_ok;
        rok_d     = r_ok;
        state_d   = (cnt_q == ROOT) ? S_DONE : S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (cl || cr) begin
          wdata    = cr ? rd_b : rd_a;
          pos_d    = child[AW-1:0];
          ch_pos   = child[AW-1:0];
          n_cur    = cnt_q;
          issue_dn = 1'b1;
          ra_a     = l_ok ? lft[AW-1:0] : '0;
          ra_b     = r_ok ? rgt[AW-1:0] : '0;
          lok_d    = l_ok;
          rok_d    = r_ok;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    val_q     <= val_d;
    pos_q     <= pos_d;
    res_key_q <= res_key_d;
    res_st_q  <= res_st_d;
    lok_q     <= lok_d;
    rok_q     <= rok_d;
    if (out_load) begin
      out_key_q <= okey_ext[31:0];
      out_st_q  <= res_st_q;
      out_cnt_q <= cnt_ext[7:0];
    end
  end

  bmhq_ram #(
    .ENTRIES (ENTRIES),
    .AW      (AW),
    .DW      (KW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (ra_a),
    .raddr_b_i (ra_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_key_o   = out_key_q;
  assign status_o    = out_st_q;
  assign count_o     = out_cnt_q;

endmodule

@@ src/bmhq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary min-heap queue port checker
// Watches the result channel of the queue and flags inconsistent results.
// ----------------------------------------------------------------------------
module bmhq_checker
  import bmhq_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] out_key_o,
  input logic [1:0]  status_o,
  input logic [7:0]  count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_key_o)
      && $stable(status_o) && $stable(count_o))
    else $error("Result changed while stalled.");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> (count_o == 8'd0) && (out_key_o == 32'd0))
    else $error("Empty status with nonzero count or key.");

  a_full_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (out_key_o == 32'd0))
    else $error("Full status with nonzero key.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK) || (status_o == ST_FULL) || (status_o == ST_EMPTY))
    else $error("Undefined status code.");

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_key_o   (out_key_o),
  .status_o    (status_o),
  .count_o     (count_o)
);
